// ===== hdl/dvc_pkg.sv =====
// Package for the distinct value counter: item types, control struct,
// controller states and fixed widths. No dependencies.
`default_nettype none
package dvc_pkg;

	localparam int unsigned VALUE_W        = 16;
	localparam int unsigned TOTAL_W        = 17;
	localparam int unsigned EPOCH_W        = 8;
	localparam int unsigned HALF_RANGE_DEF = 32768;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sample_value;
		logic                      end_of_run;
	} in_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] echo_value;
		logic                      first_seen;
		logic [TOTAL_W-1:0]        distinct_total;
		logic                      run_done;
	} out_item_t;

	typedef enum logic [0:0] {
		ST_CLEAR,
		ST_RUN
	} ctrl_state_t;

	typedef struct packed {
		logic               busy;
		logic               clr_we;
		logic [EPOCH_W-1:0] epoch;
	} ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/dvc_seen_mem.sv =====
// Seen-map memory: one write port, one read port with registered data.
// Uses no package items.
`default_nettype none
module dvc_seen_mem #(
	parameter int unsigned DEPTH  = 65536,
	parameter int unsigned ADDR_W = 16,
	parameter int unsigned DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hdl/dvc_epoch_ctrl.sv =====
// Epoch and clearing controller for the seen map: holds the current run tag
// and sweeps the memory to tag zero after reset and on tag wrap. Uses dvc_pkg.
`default_nettype none
module dvc_epoch_ctrl #(
	parameter int unsigned DEPTH  = 65536,
	parameter int unsigned ADDR_W = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              run_end,
	output dvc_pkg::ctrl_t         ctrl,
	output logic      [ADDR_W-1:0] clr_addr
);

	localparam logic [dvc_pkg::EPOCH_W-1:0] EPOCH_MAX = '1;
	localparam logic [dvc_pkg::EPOCH_W-1:0] EPOCH_ONE = dvc_pkg::EPOCH_W'(1);
	localparam logic [ADDR_W-1:0]           LAST_ADDR = ADDR_W'(DEPTH - 1);

	dvc_pkg::ctrl_state_t        state_q, state_nxt;
	logic [dvc_pkg::EPOCH_W-1:0] epoch_q;
	logic [ADDR_W-1:0]           clr_addr_q;
	logic                        sweep_done;

	assign sweep_done = (clr_addr_q == LAST_ADDR);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			dvc_pkg::ST_CLEAR: begin
				if (sweep_done) begin
					state_nxt = dvc_pkg::ST_RUN;
				end
			end
			dvc_pkg::ST_RUN: begin
				if (run_end && epoch_q == EPOCH_MAX) begin
					state_nxt = dvc_pkg::ST_CLEAR;
				end
			end
			default: state_nxt = dvc_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		ctrl.busy   = 1'b0;
		ctrl.clr_we = 1'b0;
		ctrl.epoch  = epoch_q;
		unique case (state_q)
			dvc_pkg::ST_CLEAR: begin
				ctrl.busy   = 1'b1;
				ctrl.clr_we = 1'b1;
			end
			dvc_pkg::ST_RUN: begin
				ctrl.busy   = 1'b0;
				ctrl.clr_we = 1'b0;
			end
			default: begin
				ctrl.busy   = 1'b1;
				ctrl.clr_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= dvc_pkg::ST_CLEAR;
			epoch_q    <= EPOCH_ONE;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == dvc_pkg::ST_CLEAR) begin
				clr_addr_q <= sweep_done ? '0 : clr_addr_q + ADDR_W'(1);
				if (sweep_done) begin
					epoch_q <= EPOCH_ONE;
				end
			end else if (run_end && epoch_q != EPOCH_MAX) begin
				epoch_q <= epoch_q + EPOCH_ONE;
			end
		end
	end

	assign clr_addr = clr_addr_q;

	a_sweep_ends_at_one: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dvc_pkg::ST_CLEAR && sweep_done |=> epoch_q == EPOCH_ONE)
		else $error("epoch not restarted after sweep");

	a_no_end_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dvc_pkg::ST_CLEAR |-> !run_end)
		else $error("run ended during sweep");

	a_epoch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		epoch_q != '0)
		else $error("epoch reached the cleared tag");

endmodule
`default_nettype wire

// ===== hdl/distinct_value_counter.sv =====
// Top level of the distinct value counter: address stage, seen-map
// read-modify-write stage and output register. Uses dvc_pkg, dvc_seen_mem, dvc_epoch_ctrl.
//
//  channel | signals                            | payload
//  sample  | sample_valid / sample_ready        | dvc_pkg::in_item_t
//  result  | result_valid / result_ready        | dvc_pkg::out_item_t
//
// One item per cycle unless a sweep, tag wrap or output stall holds it; the map is read
// into stage 1 on accept; tag check, map write and output load follow as stage 1 advances.
// Each map entry holds the tag of the run that last saw it, so a run ends without a sweep.
// After reset and after every 255th run the map is swept to tag zero, one entry a
// cycle through min(HALF_RANGE,32768)+min(HALF_RANGE,32767)+1 entries, sample_ready low.
// A stalled result holds in the output register; one more item may wait behind it.
`default_nettype none
module distinct_value_counter #(
	parameter int unsigned HALF_RANGE = dvc_pkg::HALF_RANGE_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          sample_valid,
	output logic               sample_ready,
	input  wire dvc_pkg::in_item_t sample,
	output logic               result_valid,
	input  wire logic          result_ready,
	output dvc_pkg::out_item_t result
);

	localparam int unsigned LO     = (HALF_RANGE < 32768) ? HALF_RANGE : 32768;
	localparam int unsigned HI     = (HALF_RANGE < 32767) ? HALF_RANGE : 32767;
	localparam int unsigned DEPTH  = LO + HI + 1;
	localparam int unsigned ADDR_W = $clog2(DEPTH);
	localparam int unsigned EXT_W  = dvc_pkg::VALUE_W + 2;
	localparam logic signed [EXT_W-1:0] LO_S = EXT_W'(LO);
	localparam logic signed [EXT_W-1:0] HI_S = EXT_W'(HI);
	localparam logic [dvc_pkg::EPOCH_W-1:0] EPOCH_MAX = '1;

	dvc_pkg::ctrl_t              ctrl;
	logic [ADDR_W-1:0]           clr_addr;
	logic [dvc_pkg::EPOCH_W-1:0] rd_data;

	logic signed [EXT_W-1:0] value_ext;
	logic signed [EXT_W-1:0] addr_ext;
	logic                    in_range;
	logic                    accept;

	logic                    valid_s1;
	dvc_pkg::in_item_t       item_s1;
	logic [ADDR_W-1:0]       addr_s1;
	logic                    inr_s1;

	logic                    lw_valid_q;
	logic [ADDR_W-1:0]       lw_addr_q;
	logic [dvc_pkg::TOTAL_W-1:0] total_q;
	logic [dvc_pkg::TOTAL_W-1:0] total_nxt;
	dvc_pkg::out_item_t      out_q;
	logic                    out_valid_q;

	logic out_free, adv_s1, hit, first, we_s1, wrap_pend, run_end;
	logic                    mem_we;
	logic [ADDR_W-1:0]       mem_waddr;
	logic [dvc_pkg::EPOCH_W-1:0] mem_wdata;

	assign value_ext = EXT_W'(sample.sample_value);
	assign addr_ext  = value_ext + LO_S;
	assign in_range  = (value_ext >= -LO_S) && (value_ext <= HI_S);

	assign out_free  = !out_valid_q || result_ready;
	assign adv_s1    = valid_s1 && out_free;
	assign wrap_pend = valid_s1 && item_s1.end_of_run && ctrl.epoch == EPOCH_MAX;
	assign sample_ready = !ctrl.busy && !wrap_pend && (!valid_s1 || adv_s1);
	assign accept    = sample_valid && sample_ready;

	// tag match, or the last entry written this run, which the registered read may miss
	assign hit       = (rd_data == ctrl.epoch) || (lw_valid_q && lw_addr_q == addr_s1);
	assign first     = inr_s1 && !hit;
	assign we_s1     = adv_s1 && first;
	assign run_end   = adv_s1 && item_s1.end_of_run;
	assign total_nxt = total_q + dvc_pkg::TOTAL_W'(first);

	assign mem_we    = ctrl.clr_we || we_s1;
	assign mem_waddr = ctrl.clr_we ? clr_addr : addr_s1;
	assign mem_wdata = ctrl.clr_we ? '0 : ctrl.epoch;

	dvc_seen_mem #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W),
		.DATA_W(dvc_pkg::EPOCH_W)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (accept),
		.raddr(addr_ext[ADDR_W-1:0]),
		.rdata(rd_data)
	);

	dvc_epoch_ctrl #(
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.run_end (run_end),
		.ctrl    (ctrl),
		.clr_addr(clr_addr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			lw_valid_q  <= 1'b0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (run_end) begin
				lw_valid_q <= 1'b0;
				total_q    <= '0;
			end else if (we_s1) begin
				lw_valid_q <= 1'b1;
				total_q    <= total_nxt;
			end
			if (adv_s1) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sample;
			addr_s1 <= addr_ext[ADDR_W-1:0];
			inr_s1  <= in_range;
		end
		if (we_s1) begin
			lw_addr_q <= addr_s1;
		end
		if (adv_s1) begin
			out_q.echo_value     <= item_s1.sample_value;
			out_q.first_seen     <= first;
			out_q.distinct_total <= total_nxt;
			out_q.run_done       <= item_s1.end_of_run;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_clear_excl_write: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clr_we |-> !we_s1 && !valid_s1)
		else $error("map write during sweep");

	a_total_restart: assert property (@(posedge clk) disable iff (!arst_n)
		run_end |=> total_q == '0 && !lw_valid_q)
		else $error("count not cleared at end of run");

	a_first_counts: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.first_seen |-> result.distinct_total != '0)
		else $error("first occurrence with zero count");

	a_repeat_not_first: assert property (@(posedge clk) disable iff (!arst_n)
		we_s1 && !item_s1.end_of_run ##1 valid_s1 && addr_s1 == $past(addr_s1)
		|-> !first)
		else $error("back-to-back repeat counted twice");

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for distinct_value_counter: directed and random runs,
// random idling on both channels, predicted results checked in order.
// Depends on dvc_pkg and the distinct_value_counter RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HALF_RANGE  = int'(dvc_pkg::HALF_RANGE_DEF);
	localparam int CYCLE_LIMIT = 2_000_000;

	class distinct_scoreboard;
		bit                          seen_map[int];
		logic [dvc_pkg::TOTAL_W-1:0] running_total = '0;
		dvc_pkg::out_item_t          expected_q[$];
		int                          errors = 0;
		int                          checked = 0;
		int                          firsts = 0;

		function void note_sample(dvc_pkg::in_item_t item);
			int                 addr;
			dvc_pkg::out_item_t exp_item;
			addr = int'(item.sample_value);
			addr = addr + HALF_RANGE;
			exp_item.first_seen = 1'b0;
			if (addr >= 0 && addr <= 2 * HALF_RANGE && !seen_map.exists(addr)) begin
				seen_map[addr] = 1'b1;
				running_total = running_total + dvc_pkg::TOTAL_W'(1);
				exp_item.first_seen = 1'b1;
				firsts++;
			end
			exp_item.echo_value = item.sample_value;
			exp_item.distinct_total = running_total;
			exp_item.run_done = item.end_of_run;
			expected_q.push_back(exp_item);
			if (item.end_of_run) begin
				seen_map.delete();
				running_total = '0;
			end
		endfunction

		function void check_result(dvc_pkg::out_item_t got);
			dvc_pkg::out_item_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result item: echo_value %0d", $signed(got.echo_value));
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.echo_value !== want.echo_value) begin
				$error("echo_value: expected %0d, got %0d",
					$signed(want.echo_value), $signed(got.echo_value));
				errors++;
			end
			if (got.first_seen !== want.first_seen) begin
				$error("first_seen: expected %0b, got %0b", want.first_seen, got.first_seen);
				errors++;
			end
			if (got.distinct_total !== want.distinct_total) begin
				$error("distinct_total: expected %0d, got %0d",
					want.distinct_total, got.distinct_total);
				errors++;
			end
			if (got.run_done !== want.run_done) begin
				$error("run_done: expected %0b, got %0b", want.run_done, got.run_done);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               sample_valid;
	logic               sample_ready;
	dvc_pkg::in_item_t  sample;
	logic               result_valid;
	logic               result_ready;
	dvc_pkg::out_item_t result;

	distinct_scoreboard sb = new();
	int src_idle_pct;
	int sink_idle_pct;
	int items_sent;
	int runs_sent;
	int cycle_count;

	distinct_value_counter #(
		.HALF_RANGE(HALF_RANGE)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		result_ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && sample_ready)
				sb.note_sample(sample);
			if (result_valid && result_ready)
				sb.check_result(result);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// entered and left at a falling edge
	task automatic send_item(input logic signed [dvc_pkg::VALUE_W-1:0] value,
		input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid <= 1'b1;
		sample.sample_value <= value;
		sample.end_of_run <= last;
		@(posedge clk);
		while (!sample_ready)
			@(posedge clk);
		items_sent++;
		if (last)
			runs_sent++;
		@(negedge clk);
	endtask

	task automatic drain_results();
		sample_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic send_run(input int len);
		logic signed [dvc_pkg::VALUE_W-1:0] value;
		logic signed [dvc_pkg::VALUE_W-1:0] prev1;
		logic signed [dvc_pkg::VALUE_W-1:0] prev2;
		int                                 pool;
		int                                 r;
		pool = $urandom_range(3);
		prev1 = '0;
		prev2 = '0;
		for (int k = 0; k < len; k++) begin
			r = $urandom_range(99);
			if (k > 0 && r < 12)
				value = prev1;
			else if (k > 1 && r < 20)
				value = prev2;
			else begin
				case (pool)
					0: value = dvc_pkg::VALUE_W'($urandom_range(7) - 4);
					1: value = dvc_pkg::VALUE_W'($urandom_range(127) - 64);
					2: value = dvc_pkg::VALUE_W'($urandom);
					default: value = $urandom_range(1)
						? dvc_pkg::VALUE_W'(32'h7FFF - $urandom_range(3))
						: dvc_pkg::VALUE_W'(32'h8000 + $urandom_range(3));
				endcase
			end
			send_item(value, k == len - 1);
			prev2 = prev1;
			prev1 = value;
		end
	endtask

	task automatic random_runs(input int item_target);
		int r;
		int len;
		while (items_sent < item_target) begin
			r = $urandom_range(99);
			if (r < 80)
				len = $urandom_range(1, 4);
			else if (r < 97)
				len = $urandom_range(5, 24);
			else
				len = $urandom_range(25, 100);
			send_run(len);
		end
	endtask

	initial begin
		sample_valid = 1'b0;
		sample = '0;
		result_ready = 1'b0;
		arst_n = 1'b0;
		src_idle_pct = 33;
		sink_idle_pct = 58;
		items_sent = 0;
		runs_sent = 0;
		cycle_count = 0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// extremes, back-to-back and spaced repeats, repeat on the last item
		send_item(-16'sd32768, 1'b0);
		send_item(16'sd32767, 1'b0);
		send_item(16'sd0, 1'b0);
		send_item(-16'sd1, 1'b0);
		send_item(16'sd1, 1'b0);
		send_item(16'sh5555, 1'b0);
		send_item(16'shAAAA, 1'b0);
		send_item(-16'sd32768, 1'b0);
		send_item(16'sd32767, 1'b0);
		send_item(16'sd5, 1'b0);
		send_item(16'sd5, 1'b0);
		send_item(16'sd5, 1'b0);
		send_item(16'sd7, 1'b0);
		send_item(16'sd5, 1'b0);
		send_item(16'sd0, 1'b1);
		// the map must be clear again after each end of run
		send_item(16'sd32767, 1'b1);
		send_item(-16'sd32768, 1'b0);
		send_item(-16'sd32768, 1'b1);
		send_item(16'sd0, 1'b1);
		send_item(16'sd0, 1'b1);

		random_runs(680);
		drain_results();

		src_idle_pct = 58;
		sink_idle_pct = 33;
		random_runs(1350);
		drain_results();

		src_idle_pct = 0;
		sink_idle_pct = 0;
		random_runs(2000);

		sample_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d items in %0d runs under three idling mixes.",
			items_sent, runs_sent);
		$display("Checked %0d results, %0d first occurrences, %0d mismatches.",
			sb.checked, sb.firsts, sb.errors);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/dvc_pkg.sv
hdl/dvc_seen_mem.sv
hdl/dvc_epoch_ctrl.sv
hdl/distinct_value_counter.sv
tb/sv/tb_top.sv
